/* rtl/tpbd_pkg.sv */
// ----------------------------------------------------------------------------
// tpbd_pkg
// Types, constants and helper functions for the tape pulse byte decoder.
// ----------------------------------------------------------------------------
package tpbd_pkg;

    // Widths of the item fields and of the configuration port.
    localparam int unsigned TimeWidth = 32;
    localparam int unsigned DurWidth  = 16;
    localparam int unsigned ByteWidth = 8;
    localparam int unsigned CfgWidth  = 32;
    localparam int unsigned CfgIdxW   = 3;

    // Padded stream data widths.
    localparam int unsigned SDataWidth = 40;
    localparam int unsigned MDataWidth = 8;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        REG_PILOT     = 3'd0,
        REG_SYNC_HIGH = 3'd1,
        REG_SYNC_LOW  = 3'd2,
        REG_ZERO      = 3'd3,
        REG_ONE       = 3'd4
    } cfg_reg_t;

    // Window register values after reset.
    localparam logic [CfgWidth-1:0] PilotWindowRst    = 32'd157288300;
    localparam logic [CfgWidth-1:0] SyncHighWindowRst = 32'd47841880;
    localparam logic [CfgWidth-1:0] SyncLowWindowRst  = 32'd52429450;
    localparam logic [CfgWidth-1:0] ZeroWindowRst     = 32'd62259960;
    localparam logic [CfgWidth-1:0] OneWindowRst      = 32'd124519900;

    // Bit mask value that selects the most significant bit of a byte.
    localparam logic [ByteWidth-1:0] ByteTopBit = 8'd128;

    // Classes of a completed high-then-low pulse pair.
    typedef enum logic [2:0] {
        CLS_IDLE  = 3'd0,
        CLS_PILOT = 3'd1,
        CLS_SYNC  = 3'd2,
        CLS_ZERO  = 3'd3,
        CLS_ONE   = 3'd4
    } pair_class_t;

    // True when a duration lies within the inclusive bounds of a window.
    // The minimum sits in the low half, the maximum in the high half.
    function automatic logic in_window(input logic [CfgWidth-1:0] win,
                                       input logic [DurWidth-1:0] dur);
        return (dur >= win[DurWidth-1:0]) && (dur <= win[CfgWidth-1:DurWidth]);
    endfunction

    // Saturate an elapsed cycle count to the duration range.
    function automatic logic [DurWidth-1:0] sat_dur(input logic [TimeWidth-1:0] elapsed);
        return (|elapsed[TimeWidth-1:DurWidth]) ? {DurWidth{1'b1}}
                                                : elapsed[DurWidth-1:0];
    endfunction

endpackage

/* rtl/tape_pulse_byte_decoder.sv */
// ----------------------------------------------------------------------------
// tape_pulse_byte_decoder
// Measures pulse widths on a tape output line and assembles data bytes.
// ----------------------------------------------------------------------------
// Each input transaction carries the level written to the tape line and the
// cycle time stamp of that write. The block measures high and low times
// (saturated to the duration range), classifies every completed high-then-low
// pair as pilot, sync, bit zero or bit one by the programmable windows, and
// shifts bits in most significant bit first. Each completed byte leaves as
// one output transaction, with m_tuser set on the first byte after a sync
// pair. An accepted item is held in the input register; the classify logic
// between the input register and the output register then loads its byte,
// if any, into the output register as the item advances. One item is
// accepted every cycle; the input stage holds only while a byte is waiting
// in the output register and m_tready is low. The user must write window
// registers only while the block is idle; the block itself does not
// enforce it.
// ----------------------------------------------------------------------------
module tape_pulse_byte_decoder
    import tpbd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    // Configuration write port.
    input  logic                   cfg_wr_en,
    input  logic [CfgIdxW-1:0]     cfg_index,
    input  logic [CfgWidth-1:0]    cfg_wdata,

    // Input stream: tdata = line_level [0], time_stamp [32:1], zero pad [39:33].
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SDataWidth-1:0]  s_tdata,

    // Output stream: tdata = data_byte [7:0]; tuser = first_of_block [0].
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [MDataWidth-1:0]  m_tdata,
    output logic                   m_tuser
);

    // Edge tracker phases.
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } phase_t;

    // Window registers.
    logic [CfgWidth-1:0]  pilot_win_reg;
    logic [CfgWidth-1:0]  sync_high_win_reg;
    logic [CfgWidth-1:0]  sync_low_win_reg;
    logic [CfgWidth-1:0]  zero_win_reg;
    logic [CfgWidth-1:0]  one_win_reg;

    // Input register.
    logic                 in_valid_reg;
    logic                 in_level_reg;
    logic [TimeWidth-1:0] in_time_reg;

    // Decoder state.
    phase_t               phase_reg, phase_next;
    logic [TimeWidth-1:0] last_time_reg;
    logic [DurWidth-1:0]  high_time_reg, high_time_next;
    logic [ByteWidth-1:0] byte_acc_reg, byte_acc_next;
    logic [ByteWidth-1:0] bit_mask_reg, bit_mask_next;
    logic                 first_pend_reg, first_pend_next;

    // Output register.
    logic                 out_valid_reg;
    logic [ByteWidth-1:0] out_byte_reg;
    logic                 out_first_reg;

    // Combinational step results.
    logic [DurWidth-1:0]  dur;
    pair_class_t          pair_class;
    logic                 emit;
    logic [ByteWidth-1:0] acc_bit;
    logic                 stall;
    logic                 advance;

    // The input stage holds only when the output register is full and blocked.
    assign stall    = in_valid_reg && out_valid_reg && !m_tready;
    assign advance  = in_valid_reg && !stall;
    assign s_tready = !stall;

    assign dur = sat_dur(in_time_reg - last_time_reg);

    // Classify the pair closed by the current high edge.
    always_comb begin
        priority if (in_window(pilot_win_reg, dur) &&
                     in_window(pilot_win_reg, high_time_reg)) begin
            pair_class = CLS_PILOT;
        end else if (in_window(sync_low_win_reg, dur) &&
                     in_window(sync_high_win_reg, high_time_reg)) begin
            pair_class = CLS_SYNC;
        end else if (in_window(zero_win_reg, dur) &&
                     in_window(zero_win_reg, high_time_reg)) begin
            pair_class = CLS_ZERO;
        end else if (in_window(one_win_reg, dur) &&
                     in_window(one_win_reg, high_time_reg)) begin
            pair_class = CLS_ONE;
        end else begin
            pair_class = CLS_IDLE;
        end
    end

    // Next state of the edge tracker and byte assembler for one item.
    always_comb begin
        phase_next      = phase_reg;
        high_time_next  = high_time_reg;
        byte_acc_next   = byte_acc_reg;
        bit_mask_next   = bit_mask_reg;
        first_pend_next = first_pend_reg;
        emit            = 1'b0;
        acc_bit         = byte_acc_reg | bit_mask_reg;

        unique case (phase_reg)
            PH_HIGH: begin
                if (in_level_reg) begin
                    phase_next = PH_IDLE;
                end else begin
                    high_time_next = dur;
                    phase_next     = PH_LOW;
                end
            end
            PH_LOW: begin
                if (!in_level_reg) begin
                    phase_next = PH_IDLE;
                end else begin
                    phase_next = PH_HIGH;
                    unique case (pair_class)
                        CLS_SYNC: begin
                            byte_acc_next   = '0;
                            bit_mask_next   = ByteTopBit;
                            first_pend_next = 1'b1;
                        end
                        CLS_ZERO, CLS_ONE: begin
                            if (pair_class == CLS_ONE) begin
                                byte_acc_next = acc_bit;
                            end
                            bit_mask_next = bit_mask_reg >> 1;
                            // The last bit of a byte completes it.
                            if (bit_mask_reg[0]) begin
                                emit            = 1'b1;
                                first_pend_next = 1'b0;
                                byte_acc_next   = '0;
                                bit_mask_next   = ByteTopBit;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                phase_next = in_level_reg ? PH_HIGH : PH_IDLE;
            end
        endcase
    end

    // Window registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pilot_win_reg     <= PilotWindowRst;
            sync_high_win_reg <= SyncHighWindowRst;
            sync_low_win_reg  <= SyncLowWindowRst;
            zero_win_reg      <= ZeroWindowRst;
            one_win_reg       <= OneWindowRst;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PILOT:     pilot_win_reg     <= cfg_wdata;
                REG_SYNC_HIGH: sync_high_win_reg <= cfg_wdata;
                REG_SYNC_LOW:  sync_low_win_reg  <= cfg_wdata;
                REG_ZERO:      zero_win_reg      <= cfg_wdata;
                REG_ONE:       one_win_reg       <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_level_reg <= s_tdata[0];
            in_time_reg  <= s_tdata[TimeWidth:1];
        end
    end

    // Decoder state, updated as each item leaves the input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            last_time_reg  <= '0;
            high_time_reg  <= '0;
            byte_acc_reg   <= '0;
            bit_mask_reg   <= ByteTopBit;
            first_pend_reg <= 1'b0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            last_time_reg  <= in_time_reg;
            high_time_reg  <= high_time_next;
            byte_acc_reg   <= byte_acc_next;
            bit_mask_reg   <= bit_mask_next;
            first_pend_reg <= first_pend_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_byte_reg  <= acc_bit & {ByteWidth{pair_class == CLS_ONE}}
                             | byte_acc_reg;
            out_first_reg <= first_pend_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_first_reg;

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tape pulse byte decoder.
// ----------------------------------------------------------------------------
// A queue of line events feeds a stream driver. A monitor decodes every
// accepted event with its own pulse tracker and byte shifter and checks
// each output byte against the oldest one predicted. The run starts with a
// hand-written sequence and then goes through several window settings with
// well-formed pilot, sync and bit sequences mixed with noise, under changing
// sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpbd_pkg::*;

    localparam int WatchdogLimit = 4000;
    localparam int SettleCycles  = 8;

    typedef struct packed {
        logic                 level;
        logic [TimeWidth-1:0] stamp;
    } line_event_t;

    typedef struct packed {
        logic [ByteWidth-1:0] value;
        logic                 first;
    } tape_byte_t;

    typedef enum logic [1:0] {
        TRK_IDLE,
        TRK_SAW_HIGH,
        TRK_SAW_LOW
    } pulse_tracker_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    cfg_reg_t              cfg_index = REG_PILOT;
    logic [CfgWidth-1:0]   cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // line_level [0], time_stamp [32:1], zero pad [39:33]
    logic [SDataWidth-1:0] s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // data_byte [7:0]
    logic [MDataWidth-1:0] m_tdata;
    // first_of_block [0]
    logic                  m_tuser;

    // Stimulus and checking state.
    line_event_t          pending_events[$];
    tape_byte_t           awaited_bytes[$];
    logic [TimeWidth-1:0] tape_clock;
    int                   queued_total   = 0;
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    bit                   hold_sender    = 1'b0;
    bit                   in_accepted    = 1'b0;
    int                   idle_cycles    = 0;
    int                   fail_count     = 0;
    int                   events_seen    = 0;
    int                   bytes_seen     = 0;
    int                   class_seen[5]  = '{default: 0};

    // Predictor copy of the window registers and of the decoder state.
    logic [CfgWidth-1:0]  win_cfg[5] = '{PilotWindowRst, SyncHighWindowRst,
                                         SyncLowWindowRst, ZeroWindowRst,
                                         OneWindowRst};
    pulse_tracker_t       tracker     = TRK_IDLE;
    logic [TimeWidth-1:0] prev_stamp  = '0;
    logic [DurWidth-1:0]  meas_high   = '0;
    logic [DurWidth-1:0]  meas_low    = '0;
    logic [ByteWidth-1:0] shift_byte  = '0;
    logic [ByteWidth-1:0] shift_mask  = ByteTopBit;
    logic                 block_start = 1'b0;

    tape_pulse_byte_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Inclusive window test: minimum in the low half, maximum in the high half.
    function automatic bit fits(input logic [CfgWidth-1:0] win,
                                input logic [DurWidth-1:0] d);
        return (d >= win[15:0]) && (d <= win[31:16]);
    endfunction

    // Windows are tried in priority order; the first match wins.
    function automatic pair_class_t classify_pair(input logic [DurWidth-1:0] hi_t,
                                                  input logic [DurWidth-1:0] lo_t);
        if (fits(win_cfg[REG_PILOT], lo_t) && fits(win_cfg[REG_PILOT], hi_t))
            return CLS_PILOT;
        if (fits(win_cfg[REG_SYNC_LOW], lo_t) && fits(win_cfg[REG_SYNC_HIGH], hi_t))
            return CLS_SYNC;
        if (fits(win_cfg[REG_ZERO], lo_t) && fits(win_cfg[REG_ZERO], hi_t))
            return CLS_ZERO;
        if (fits(win_cfg[REG_ONE], lo_t) && fits(win_cfg[REG_ONE], hi_t))
            return CLS_ONE;
        return CLS_IDLE;
    endfunction

    // Advance the pulse tracker by one line event and queue any finished byte.
    task automatic decode_event(input logic lvl, input logic [TimeWidth-1:0] stamp);
        logic [TimeWidth-1:0] gap;
        logic [DurWidth-1:0]  dur;
        pair_class_t          cls;
        gap        = stamp - prev_stamp;
        dur        = (gap > 32'd65535) ? 16'hFFFF : gap[DurWidth-1:0];
        prev_stamp = stamp;
        case (tracker)
            TRK_SAW_HIGH: begin
                if (lvl) begin
                    tracker = TRK_IDLE;
                end else begin
                    meas_high = dur;
                    tracker   = TRK_SAW_LOW;
                end
            end
            TRK_SAW_LOW: begin
                if (!lvl) begin
                    tracker = TRK_IDLE;
                end else begin
                    meas_low = dur;
                    tracker  = TRK_SAW_HIGH;
                    cls      = classify_pair(meas_high, meas_low);
                    class_seen[int'(cls)]++;
                    if (cls == CLS_SYNC) begin
                        shift_byte  = '0;
                        shift_mask  = ByteTopBit;
                        block_start = 1'b1;
                    end else if (cls == CLS_ZERO || cls == CLS_ONE) begin
                        if (cls == CLS_ONE)
                            shift_byte = shift_byte | shift_mask;
                        shift_mask = shift_mask >> 1;
                        if (shift_mask == '0) begin
                            awaited_bytes.insert(awaited_bytes.size(),
                                                 tape_byte_t'{shift_byte, block_start});
                            block_start = 1'b0;
                            shift_byte  = '0;
                            shift_mask  = ByteTopBit;
                        end
                    end
                end
            end
            default: begin
                tracker = lvl ? TRK_SAW_HIGH : TRK_IDLE;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: one input transaction at a time from the pending queue.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive_line
        line_event_t ev;
        m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_accepted) begin
            if (!hold_sender && pending_events.size() != 0 &&
                $urandom_range(99, 0) >= send_idle_pct) begin
                ev = pending_events.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'b0, ev.stamp, ev.level};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on input transactions, check output transactions.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : watch_ports
        tape_byte_t want;
        in_accepted = aresetn && s_tvalid && s_tready;
        if (!aresetn) begin
            idle_cycles = 0;
        end else begin
            if (in_accepted) begin
                decode_event(s_tdata[0], s_tdata[32:1]);
                events_seen++;
            end
            if (m_tvalid && m_tready) begin
                bytes_seen++;
                if (awaited_bytes.size() == 0) begin
                    $display("%0t: unexpected byte, expected none, got %02h first %0b",
                             $time, m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    want = awaited_bytes.pop_front();
                    if (m_tdata !== want.value) begin
                        $display("%0t: data_byte mismatch, expected %02h, got %02h",
                                 $time, want.value, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== want.first) begin
                        $display("%0t: first_of_block mismatch, expected %0b, got %0b",
                                 $time, want.first, m_tuser);
                        fail_count++;
                    end
                end
            end
            idle_cycles = (in_accepted || (m_tvalid && m_tready)) ? 0 : idle_cycles + 1;
        end
    end

    // Give up when no transaction moves on either side for too long.
    initial begin : watchdog
        @(posedge aresetn);
        while (idle_cycles < WatchdogLimit) @(posedge aclk);
        $display("%0t: no transaction for %0d cycles", $time, WatchdogLimit);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    // Queue one line event that follows the previous one after dur cycles.
    task automatic add_event(input logic lvl, input logic [TimeWidth-1:0] dur);
        tape_clock = tape_clock + dur;
        pending_events.insert(pending_events.size(), line_event_t'{lvl, tape_clock});
        queued_total++;
    endtask

    // A high period of hi_len followed by a low period of lo_len.
    task automatic add_pair(input logic [TimeWidth-1:0] hi_len,
                            input logic [TimeWidth-1:0] lo_len);
        add_event(1'b0, hi_len);
        add_event(1'b1, lo_len);
    endtask

    // A duration inside a window, often on one of its bounds; any duration if the window is inverted.
    function automatic logic [TimeWidth-1:0] window_duration(input cfg_reg_t r);
        logic [15:0] lo;
        logic [15:0] hi;
        int          pick;
        lo   = win_cfg[r][15:0];
        hi   = win_cfg[r][31:16];
        pick = $urandom_range(9, 0);
        if (lo > hi)
            return $urandom_range(65535, 0);
        if (pick == 0)
            return {16'd0, lo};
        if (pick == 1)
            return {16'd0, hi};
        return $urandom_range(hi, lo);
    endfunction

    // Durations for broken pulses: short, full range, saturating, zero or inside a random window.
    function automatic logic [TimeWidth-1:0] noise_duration();
        case ($urandom_range(9, 0))
            0, 1, 2, 3: return $urandom_range(3000, 0);
            4, 5:       return $urandom_range(65535, 0);
            6:          return $urandom;
            7:          return '0;
            default:    return window_duration(cfg_reg_t'($urandom_range(4, 0)));
        endcase
    endfunction

    // A mostly well-formed block: leader, pilot pulses, usually a sync, then bits, mostly whole bytes.
    // The leading low/high pair always leaves the tracker waiting for low.
    task automatic add_block();
        int n_bits;
        add_event(1'b0, noise_duration());
        add_event(1'b1, noise_duration());
        repeat ($urandom_range(4, 0))
            add_pair(window_duration(REG_PILOT), window_duration(REG_PILOT));
        if ($urandom_range(9, 0) != 0)
            add_pair(window_duration(REG_SYNC_HIGH), window_duration(REG_SYNC_LOW));
        n_bits = 8 * $urandom_range(3, 1);
        if ($urandom_range(7, 0) == 0)
            n_bits = n_bits + $urandom_range(6, 0) - 3;
        repeat (n_bits) begin
            if ($urandom_range(19, 0) == 0)
                add_pair(noise_duration(), noise_duration());
            else if ($urandom_range(1, 0) == 1)
                add_pair(window_duration(REG_ONE), window_duration(REG_ONE));
            else
                add_pair(window_duration(REG_ZERO), window_duration(REG_ZERO));
        end
    endtask

    task automatic gen_items(input int count);
        int start;
        start = queued_total;
        while (queued_total - start < count) begin
            if ($urandom_range(9, 0) < 7) begin
                add_block();
            end else begin
                repeat ($urandom_range(6, 1))
                    add_event(1'($urandom_range(1, 0)), noise_duration());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------

    task automatic write_window(input cfg_reg_t r, input logic [CfgWidth-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= val;
        win_cfg[r] = val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_windows(input logic [CfgWidth-1:0] pilot,
                                input logic [CfgWidth-1:0] sync_hi,
                                input logic [CfgWidth-1:0] sync_lo,
                                input logic [CfgWidth-1:0] zero,
                                input logic [CfgWidth-1:0] one);
        write_window(REG_PILOT, pilot);
        write_window(REG_SYNC_HIGH, sync_hi);
        write_window(REG_SYNC_LOW, sync_lo);
        write_window(REG_ZERO, zero);
        write_window(REG_ONE, one);
    endtask

    // Mostly sane windows, sometimes fully random ones.
    function automatic logic [CfgWidth-1:0] rand_window();
        logic [15:0] lo;
        if ($urandom_range(3, 0) == 0)
            return $urandom;
        lo = $urandom_range(3000, 0);
        return {lo + 16'($urandom_range(800, 0)), lo};
    endfunction

    // Hold the sender until every byte has come out and the pipe is empty.
    task automatic quiesce();
        hold_sender = 1'b1;
        do @(posedge aclk); while (s_tvalid || awaited_bytes.size() != 0);
        repeat (SettleCycles) @(posedge aclk);
        hold_sender = 1'b0;
    endtask

    task automatic drain_queue();
        while (pending_events.size() != 0) @(posedge aclk);
    endtask

    // Each phase pauses halfway until the decoder has caught up.
    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        gen_items(count / 2);
        drain_queue();
        quiesce();
        gen_items(count - count / 2);
        drain_queue();
        quiesce();
    endtask

    // Hand-written opening sequence against the reset windows.
    task automatic directed_items();
        // Saturated first gap, with the time base placed so stamps wrap soon.
        tape_clock = 32'hFFFF_E000;
        add_event(1'b0, '0);
        // Repeated high, then repeated low, both drop the tracker to idle.
        add_event(1'b1, 32'd10);
        add_event(1'b1, 32'd10);
        add_event(1'b1, 32'd10);
        add_event(1'b0, 32'd10);
        add_event(1'b0, 32'd10);
        add_event(1'b1, 32'd10);
        // Sync pair on the lower bounds of both sync windows.
        add_pair(32'd600, 32'd650);
        // Byte 1010_0110 with window bounds, and a pilot pair inside it.
        add_pair(32'd1500, 32'd1899);
        add_pair(32'd760, 32'd950);
        add_pair(32'd1600, 32'd1600);
        add_pair(32'd1900, 32'd1900);
        add_pair(32'd950, 32'd760);
        add_pair(32'd900, 32'd900);
        add_pair(32'd1899, 32'd1500);
        add_pair(32'd1600, 32'd1600);
        add_pair(32'd800, 32'd800);
    endtask

    initial begin : main_sequence
        tape_clock = $urandom;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset windows: directed sequence, then random blocks at full rate.
        directed_items();
        drain_queue();
        quiesce();
        run_phase(0, 0, 300);

        // Narrow, separated windows.
        load_windows({16'd400, 16'd300}, {16'd150, 16'd100}, {16'd200, 16'd160},
                     {16'd40, 16'd20}, {16'd80, 16'd50});
        run_phase(88, 0, 260);
        run_phase(0, 88, 260);

        // Extremes: inverted pilot, zero-only and saturated-only sync bounds,
        // full-range bit zero.
        load_windows(32'h0000_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                     32'hFFFF_0000, 32'hFFFF_FFFF);
        run_phase(25, 25, 180);

        load_windows(rand_window(), rand_window(), rand_window(),
                     rand_window(), rand_window());
        run_phase(25, 25, 200);

        // Extremes the other way: saturated-only pilot, full-range sync high,
        // zero-length sync low and bit zero, full-range bit one.
        load_windows(32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0000_0000,
                     32'h0000_0000, 32'hFFFF_0000);
        run_phase(0, 0, 180);

        load_windows(PilotWindowRst, SyncHighWindowRst, SyncLowWindowRst,
                     ZeroWindowRst, OneWindowRst);
        run_phase(25, 25, 200);

        if (awaited_bytes.size() != 0) begin
            $display("%0t: %0d predicted bytes never came out", $time,
                     awaited_bytes.size());
            fail_count++;
        end
        $display("Decoded %0d line events into %0d bytes over six window settings.",
                 events_seen, bytes_seen);
        $display("Pairs seen as idle/pilot/sync/zero/one: %0d/%0d/%0d/%0d/%0d.",
                 class_seen[0], class_seen[1], class_seen[2], class_seen[3],
                 class_seen[4]);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
